// ----- rtl/pcdq_pkg.sv -----
// shared constants, codes and types for the per-client delay queue
`timescale 1ns / 1ps
package pcdq_pkg;

    localparam int NUM_CLIENTS   = 64;
    localparam int POOL_ENTRIES  = 1024;
    localparam int MAX_DELAY_MS  = 2000;
    localparam int COMMAND_WIDTH = 64;

    localparam int MS_PER_SEC = 1000;
    localparam int CLI_W      = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int ENT_W      = $clog2(POOL_ENTRIES);
    localparam int PTR_W      = ENT_W + 1;
    localparam int DLY_W      = 11;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

    localparam logic [2:0] MODE_STORE    = 3'd0;
    localparam logic [2:0] MODE_FETCH    = 3'd1;
    localparam logic [2:0] MODE_SET_LAG  = 3'd2;
    localparam logic [2:0] MODE_SET_VAR  = 3'd3;
    localparam logic [2:0] MODE_FLUSH    = 3'd4;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_RELEASED = 3'd1;
    localparam logic [2:0] ST_NONE_DUE = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_SET      = 3'd4;
    localparam logic [2:0] ST_DISABLED = 3'd5;
    localparam logic [2:0] ST_BAD      = 3'd6;
    localparam logic [2:0] ST_FLUSHED  = 3'd7;

    localparam logic REG_LAG_ENABLED  = 1'b0;
    localparam logic REG_CLIENT_LIMIT = 1'b1;

    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         client_index;
        logic [7:0]         elapsed_ms;
        logic [63:0]        command_bits;
        logic [31:0]        origin_x;
        logic [31:0]        origin_y;
        logic [31:0]        origin_z;
        logic [31:0]        angle_x;
        logic [31:0]        angle_y;
        logic [31:0]        angle_z;
        logic signed [31:0] setting_value;
        logic signed [15:0] jitter_sample;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [63:0]      out_command;
        logic [31:0]      out_origin_x;
        logic [31:0]      out_origin_y;
        logic [31:0]      out_origin_z;
        logic [31:0]      out_angle_x;
        logic [31:0]      out_angle_y;
        logic [31:0]      out_angle_z;
        logic [DLY_W-1:0] current_delay;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic crd;
        logic cex;
        logic ex2;
        logic ex3;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/pcdq_ctrl.sv -----
// sequencer that steps one item through the datapath phases
`timescale 1ns / 1ps
module pcdq_ctrl import pcdq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRD,
        S_CEX,
        S_EX2,
        S_EX3,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CRD;
            S_CRD:   n_state = S_CEX;
            S_CEX:   n_state = S_EX2;
            S_EX2:   n_state = S_EX3;
            S_EX3:   n_state = S_HOLD;
            S_HOLD:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.crd      = (r_state == S_CRD);
    assign o_cmd.cex      = (r_state == S_CEX);
    assign o_cmd.ex2      = (r_state == S_EX2);
    assign o_cmd.ex3      = (r_state == S_EX3);
    assign o_cmd.load_out = (r_state == S_HOLD) && i_sts.out_free;

endmodule

// ----- rtl/pcdq_dp.sv -----
// datapath: client table, entry pool, link memory, delay and age arithmetic
`timescale 1ns / 1ps
module pcdq_dp import pcdq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  t_in_item   i_item,
    input  logic       i_lag_enabled,
    input  logic [6:0] i_client_limit,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out
);

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [DLY_W-1:0] lag;
        logic [DLY_W-1:0] variance;
        logic [DLY_W-1:0] delay;
        logic [31:0]      sec;
        logic [10:0]      ms;
    } t_client_rec;

    typedef struct packed {
        logic [COMMAND_WIDTH-1:0] cmd;
        logic [31:0]              ox;
        logic [31:0]              oy;
        logic [31:0]              oz;
        logic [31:0]              ax;
        logic [31:0]              ay;
        logic [31:0]              az;
        logic [31:0]              stamp_sec;
        logic [9:0]               stamp_ms;
    } t_entry;

    localparam t_client_rec REC_RESET = '{head: NIL, tail: NIL, default: '0};

    t_client_rec m_client [NUM_CLIENTS];
    t_entry      m_pl     [POOL_ENTRIES];
    logic [PTR_W-1:0] m_link [POOL_ENTRIES];

    logic [NUM_CLIENTS-1:0] r_cvalid;
    logic [PTR_W-1:0]       r_free_head;
    logic [PTR_W-1:0]       r_fill;
    t_in_item               r_in;
    logic                   r_bad;
    t_client_rec            r_crd_data;
    logic                   r_crd_valid;
    t_client_rec            r_crec;
    logic                   r_roll;
    logic signed [27:0]     r_prod;
    logic                   r_use_free;
    logic                   r_full;
    logic                   r_empty;
    logic [ENT_W-1:0]       r_ent;
    logic [PTR_W-1:0]       r_link_rd;
    t_entry                 r_pl_rd;
    logic [41:0]            r_age_prod;
    logic [2:0]             r_status;
    logic [DLY_W-1:0]       r_res_delay;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [CLI_W-1:0] cidx;
    logic             bad;
    t_client_rec      rec;
    logic [10:0]      ms_sum;
    logic             roll;
    logic             use_free;
    logic [DLY_W-1:0] set_clamped;
    logic signed [28:0] dsum;
    logic signed [13:0] dquot;
    logic [DLY_W-1:0] delay_new;
    logic [31:0]      sec_diff;
    logic signed [43:0] age;
    logic signed [43:0] due_lim;
    logic             due;

    logic             cl_we;
    t_client_rec      cl_wdata;
    logic             lk_we;
    logic [ENT_W-1:0] lk_waddr;
    logic [PTR_W-1:0] lk_wdata;
    logic [ENT_W-1:0] lk_raddr;
    logic             pl_we;
    t_entry           pl_wdata;

    assign cidx = r_in.client_index[CLI_W-1:0];
    assign bad  = ({1'b0, r_in.client_index} >= 9'(NUM_CLIENTS))
               || (r_in.client_index >= {1'b0, i_client_limit});
    assign rec  = r_crd_valid ? r_crd_data : REC_RESET;

    // a store adds at most 255 ms to a clock below 1001, so one rollover at most
    assign ms_sum   = rec.ms + {3'b0, r_in.elapsed_ms};
    assign roll     = ms_sum > 11'(MS_PER_SEC);
    assign use_free = (r_free_head != NIL);

    always_comb begin
        if (r_in.setting_value < 0) begin
            set_clamped = '0;
        end else if (r_in.setting_value > 32'sd0 + MAX_DELAY_MS) begin
            set_clamped = DLY_W'(MAX_DELAY_MS);
        end else begin
            set_clamped = r_in.setting_value[DLY_W-1:0];
        end
    end

    // lag*32768 + jitter*variance, truncated toward zero; negative clamps to zero
    assign dsum  = $signed({3'b0, r_crec.lag, 15'b0}) + 29'(r_prod);
    assign dquot = dsum[28:15];
    always_comb begin
        if (dsum < 0) begin
            delay_new = '0;
        end else if (dquot > 14'sd0 + MAX_DELAY_MS) begin
            delay_new = DLY_W'(MAX_DELAY_MS);
        end else begin
            delay_new = dquot[DLY_W-1:0];
        end
    end

    // seconds difference wraps at 32 bits
    assign sec_diff = r_crec.sec - r_pl_rd.stamp_sec;

    assign age = $signed({2'b0, r_age_prod}) + $signed({33'b0, r_crec.ms})
               - $signed({34'b0, r_pl_rd.stamp_ms});
    assign due_lim = $signed({33'b0, r_crec.delay}) - 44'sd1;
    assign due     = (age >= due_lim);

    always_comb begin
        cl_we    = 1'b0;
        cl_wdata = r_crec;
        lk_we    = 1'b0;
        lk_waddr = r_ent;
        lk_wdata = NIL;
        lk_raddr = rec.head[ENT_W-1:0];
        pl_we    = 1'b0;
        pl_wdata = '{cmd: r_in.command_bits[COMMAND_WIDTH-1:0],
                     ox: r_in.origin_x, oy: r_in.origin_y, oz: r_in.origin_z,
                     ax: r_in.angle_x, ay: r_in.angle_y, az: r_in.angle_z,
                     stamp_sec: r_crec.sec, stamp_ms: r_crec.ms[9:0]};
        if (r_in.mode == MODE_STORE) begin
            lk_raddr = r_free_head[ENT_W-1:0];
        end
        if (i_cmd.cex && !bad) begin
            case (r_in.mode)
                MODE_SET_LAG: begin
                    if (i_lag_enabled) begin
                        cl_we          = 1'b1;
                        cl_wdata       = rec;
                        cl_wdata.lag   = set_clamped;
                        cl_wdata.delay = set_clamped;
                    end
                end
                MODE_SET_VAR: begin
                    if (i_lag_enabled) begin
                        cl_we             = 1'b1;
                        cl_wdata          = rec;
                        cl_wdata.variance = set_clamped;
                    end
                end
                MODE_FLUSH: begin
                    // splice the whole queue onto the free list
                    if (rec.head != NIL && rec.tail != NIL) begin
                        lk_we    = 1'b1;
                        lk_waddr = rec.tail[ENT_W-1:0];
                        lk_wdata = r_free_head;
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.ex2 && !r_bad && r_in.mode == MODE_STORE && !r_full) begin
            pl_we    = 1'b1;
            lk_we    = 1'b1;
            lk_waddr = r_ent;
            lk_wdata = NIL;
        end
        if (i_cmd.ex3 && !r_bad) begin
            if (r_in.mode == MODE_STORE) begin
                cl_we = 1'b1;
                if (!r_full && r_link_rd != NIL && r_crec.head != PTR_W'(r_ent)) begin
                    lk_we    = 1'b1;
                    lk_waddr = r_link_rd[ENT_W-1:0];
                    lk_wdata = PTR_W'(r_ent);
                end
            end else if (r_in.mode == MODE_FETCH && !r_empty && due) begin
                cl_we         = 1'b1;
                cl_wdata.head = (r_link_rd == NIL) ? NIL : r_link_rd;
                cl_wdata.tail = (r_link_rd == NIL) ? NIL : r_crec.tail;
                lk_we         = 1'b1;
                lk_waddr      = r_ent;
                lk_wdata      = r_free_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cl_we) begin
            m_client[cidx] <= cl_wdata;
        end
        if (i_cmd.crd) begin
            r_crd_data <= m_client[cidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            m_link[lk_waddr] <= lk_wdata;
        end
        if (i_cmd.cex) begin
            r_link_rd <= m_link[lk_raddr];
        end else if (i_cmd.ex2 && r_in.mode == MODE_STORE) begin
            // the old tail is kept here for the link write of the next phase
            r_link_rd <= r_crec.tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            m_pl[r_ent] <= pl_wdata;
        end
        if (i_cmd.cex) begin
            r_pl_rd <= m_pl[rec.head[ENT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid    <= '0;
            r_free_head <= NIL;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_in <= i_item;
            end
            if (i_cmd.crd) begin
                r_bad       <= bad;
                r_crd_valid <= r_cvalid[cidx];
            end
            if (cl_we) begin
                r_cvalid[cidx] <= 1'b1;
            end
            if (i_cmd.cex) begin
                r_crec      <= rec;
                r_res_delay <= rec.delay;
                r_status    <= ST_NONE_DUE;
                if (r_bad) begin
                    r_status    <= ST_BAD;
                    r_res_delay <= '0;
                end else begin
                    case (r_in.mode)
                        MODE_STORE: begin
                            r_crec.ms  <= roll ? ms_sum - 11'(MS_PER_SEC) : ms_sum;
                            r_crec.sec <= rec.sec + {31'b0, roll};
                            r_roll     <= roll;
                            r_prod     <= r_in.jitter_sample * $signed({1'b0, rec.variance});
                            r_use_free <= use_free;
                            r_full     <= !use_free && (r_fill == NIL);
                            r_ent      <= use_free ? r_free_head[ENT_W-1:0]
                                                   : r_fill[ENT_W-1:0];
                        end
                        MODE_FETCH: begin
                            r_empty <= (rec.head == NIL);
                            r_ent   <= rec.head[ENT_W-1:0];
                        end
                        MODE_SET_LAG: begin
                            r_status <= i_lag_enabled ? ST_SET : ST_DISABLED;
                            if (i_lag_enabled) begin
                                r_res_delay <= set_clamped;
                            end
                        end
                        MODE_SET_VAR: begin
                            r_status <= i_lag_enabled ? ST_SET : ST_DISABLED;
                        end
                        MODE_FLUSH: begin
                            r_status       <= ST_FLUSHED;
                            r_res_delay    <= '0;
                            r_cvalid[cidx] <= 1'b0;
                            if (rec.head != NIL && rec.tail != NIL) begin
                                r_free_head <= rec.head;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (i_cmd.ex2 && !r_bad) begin
                if (r_in.mode == MODE_STORE) begin
                    if (r_roll) begin
                        r_crec.delay <= delay_new;
                    end
                    r_res_delay <= r_roll ? delay_new : r_crec.delay;
                    r_status    <= r_full ? ST_FULL : ST_STORED;
                    if (!r_full) begin
                        r_crec.tail <= PTR_W'(r_ent);
                        if (r_crec.tail == NIL) begin
                            r_crec.head <= PTR_W'(r_ent);
                        end
                        if (r_use_free) begin
                            r_free_head <= r_link_rd;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end else if (r_in.mode == MODE_FETCH) begin
                    r_age_prod <= {10'b0, sec_diff} * 42'(MS_PER_SEC);
                end
            end
            if (i_cmd.ex3 && !r_bad && r_in.mode == MODE_FETCH && !r_empty && due) begin
                r_status    <= ST_RELEASED;
                r_free_head <= PTR_W'(r_ent);
            end
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_out.status        <= r_status;
                r_out.current_delay <= r_res_delay;
                if (r_status == ST_RELEASED) begin
                    r_out.out_command  <= 64'(r_pl_rd.cmd);
                    r_out.out_origin_x <= r_pl_rd.ox;
                    r_out.out_origin_y <= r_pl_rd.oy;
                    r_out.out_origin_z <= r_pl_rd.oz;
                    r_out.out_angle_x  <= r_pl_rd.ax;
                    r_out.out_angle_y  <= r_pl_rd.ay;
                    r_out.out_angle_z  <= r_pl_rd.az;
                end else begin
                    r_out.out_command  <= '0;
                    r_out.out_origin_x <= '0;
                    r_out.out_origin_y <= '0;
                    r_out.out_origin_z <= '0;
                    r_out.out_angle_x  <= '0;
                    r_out.out_angle_y  <= '0;
                    r_out.out_angle_z  <= '0;
                end
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NIL)
        else $error("fill count beyond pool size");

    a_free_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head == NIL || r_free_head < r_fill)
        else $error("free list head points at a never used entry");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_RELEASED |-> r_out.out_command == '0)
        else $error("payload shown on a non release result");

    a_bad_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_BAD |-> r_out.current_delay == '0)
        else $error("bad client result carries a delay");

endmodule

// ----- rtl/per_client_delay_queue.sv -----
// top level: stream ports, config registers, sequencer and datapath
// one item at a time: a new item is taken only once the last result is loaded into
// the output register, which waits while the output is busy; each item walks the client
// table read, the entry pool and link memory read-modify-write phases one after another
// a flush splices the whole client queue onto the free list in one step
// reset (i_rst_n low, synchronous) empties all queues and zeroes every client;
// no clearing pass is needed, entries are handed out from a fill count
`timescale 1ns / 1ps
module per_client_delay_queue import pcdq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // client_index, elapsed_ms, command_bits, origin_x/y/z, angle_x/y/z,
    // setting_value, jitter_sample
    input  logic [319:0] s_axis_tdata,
    // mode
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_command, out_origin_x/y/z, out_angle_x/y/z, current_delay, zero pad
    output logic [271:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic       r_lag_enabled;
    logic [6:0] r_client_limit;
    t_dp_cmd    cmd;
    t_dp_sts    sts;
    t_in_item   item;
    t_out_item  res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_enabled  <= 1'b0;
            r_client_limit <= 7'd64;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_LAG_ENABLED:  r_lag_enabled  <= pwdata[0];
                REG_CLIENT_LIMIT: r_client_limit <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LAG_ENABLED:  prdata = {31'b0, r_lag_enabled};
            REG_CLIENT_LIMIT: prdata = {25'b0, r_client_limit};
            default:          prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    assign item.mode          = s_axis_tuser;
    assign item.client_index  = s_axis_tdata[7:0];
    assign item.elapsed_ms    = s_axis_tdata[15:8];
    assign item.command_bits  = s_axis_tdata[79:16];
    assign item.origin_x      = s_axis_tdata[111:80];
    assign item.origin_y      = s_axis_tdata[143:112];
    assign item.origin_z      = s_axis_tdata[175:144];
    assign item.angle_x       = s_axis_tdata[207:176];
    assign item.angle_y       = s_axis_tdata[239:208];
    assign item.angle_z       = s_axis_tdata[271:240];
    assign item.setting_value = s_axis_tdata[303:272];
    assign item.jitter_sample = s_axis_tdata[319:304];

    pcdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pcdq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_item         (item),
        .i_lag_enabled  (r_lag_enabled),
        .i_client_limit (r_client_limit),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out          (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {5'b0, res.current_delay, res.out_angle_z, res.out_angle_y,
                           res.out_angle_x, res.out_origin_z, res.out_origin_y,
                           res.out_origin_x, res.out_command};

endmodule
